[rtl/assert_macros.svh]
// Assertion macros shared by the stack RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When ante holds, cons must hold at the next clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/lsp_pkg.sv]
// Shared types and constants for the LIFO stack with peek.
`timescale 1ns / 1ps

package lsp_pkg;

   localparam int OPCODE_W = 3;
   localparam int WORD_W   = 32;
   localparam int POS_W    = 5;
   localparam int CAP_W    = 5;
   localparam int STATUS_W = 2;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_PEEK   = 3'd2,
      OP_TOP    = 3'd3,
      OP_BOTTOM = 3'd4,
      OP_STATUS = 3'd5
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_BADPEEK   = 2'd3
   } status_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;   // capture the incoming item
      logic exec;   // run the stack operation on the captured item
   } ctl_cmd_type;

endpackage

[rtl/lsp_ctrl.sv]
// Controller state machine for the LIFO stack: accept, execute, respond.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lsp_ctrl import lsp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output logic        rsp_valid,
   output ctl_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_RESP
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      exec_ff;
   logic      rsp_valid_ff;
   logic      accept;

   assign accept = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         exec_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_EXEC;
                  busy_ff  <= 1'b1;
                  exec_ff  <= 1'b1;
               end
            end
            S_EXEC: begin
               state_ff     <= S_RESP;
               busy_ff      <= 1'b0;
               exec_ff      <= 1'b0;
               rsp_valid_ff <= 1'b1;
            end
            S_RESP: begin
               // a new item may be taken while the result is on the ports
               rsp_valid_ff <= 1'b0;
               if (accept) begin
                  state_ff <= S_EXEC;
                  busy_ff  <= 1'b1;
                  exec_ff  <= 1'b1;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff     <= S_IDLE;
               busy_ff      <= 1'b0;
               exec_ff      <= 1'b0;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign cmd.load  = accept;
   assign cmd.exec  = exec_ff;

   `ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid_ff, !rsp_valid_ff, "result strobe longer than one cycle")
   `ASSERT_NEXT(a_load_then_exec, clock, reset, accept, busy_ff && exec_ff, "accepted item not executed next cycle")
   `ASSERT_NEXT(a_exec_then_rsp, clock, reset, exec_ff, rsp_valid_ff && !busy_ff, "executed item gave no result")
   `ASSERT_ALWAYS(a_rsp_not_busy, clock, reset, !rsp_valid_ff || !exec_ff, "execute overlaps result cycle")

endmodule

[rtl/lsp_dpath.sv]
// Datapath for the LIFO stack: entry memory, count, capacity and result registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lsp_dpath import lsp_pkg::*; #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ctl_cmd_type                cmd,
   input  logic [OPCODE_W-1:0]        req_opcode,
   input  logic signed [WORD_W-1:0]   req_push_value,
   input  logic [POS_W-1:0]           req_peek_position,
   input  logic                       csr_wr_en,
   input  logic [CAP_W-1:0]           csr_wr_data,
   output logic signed [WORD_W-1:0]   rsp_read_data,
   output logic [STATUS_W-1:0]        rsp_status_code,
   output logic                       rsp_is_empty,
   output logic                       rsp_is_full
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   logic [CAP_W-1:0]        cap_ff;
   logic [CW-1:0]           count_ff;
   logic [CW-1:0]           count_in;

   opcode_type              op_ff;
   logic [WORD_W-1:0]       push_ff;
   logic [POS_W-1:0]        pos_ff;

   logic [DATA_WIDTH-1:0]   rd_data_ff;
   status_type              status_ff;
   status_type              status_in;
   logic                    data_ok_ff;
   logic                    data_ok_in;
   logic                    empty_ff;
   logic                    empty_in;
   logic                    full_ff;
   logic                    full_in;

   logic [CMPW-1:0]         count_x;
   logic [CMPW-1:0]         cap_x;
   logic [CMPW-1:0]         cap_eff;
   logic [CMPW-1:0]         pos_x;
   logic [CMPW-1:0]         top_idx;
   logic [CMPW-1:0]         peek_idx;
   logic [CMPW-1:0]         rd_idx;
   logic [CMPW-1:0]         count_new;
   logic                    wr_en;
   logic [63:0]             push_wide;
   logic [63:0]             rd_wide;

   assign count_x  = CMPW'(count_ff);
   assign cap_x    = CMPW'(cap_ff);
   assign pos_x    = CMPW'(pos_ff);
   assign top_idx  = count_x - CMPW'(1);
   assign peek_idx = count_x - pos_x;

   // capacity of zero acts as one, above the depth acts as the depth
   always_comb begin
      if (cap_x == '0) begin
         cap_eff = CMPW'(1);
      end else if (cap_x > CMPW'(DEPTH)) begin
         cap_eff = CMPW'(DEPTH);
      end else begin
         cap_eff = cap_x;
      end
   end

   always_comb begin
      status_in  = ST_OK;
      data_ok_in = 1'b0;
      wr_en      = 1'b0;
      count_new  = count_x;
      rd_idx     = top_idx;
      unique case (op_ff)
         OP_PUSH: begin
            if (count_x >= cap_eff) begin
               status_in = ST_OVERFLOW;
            end else begin
               wr_en     = 1'b1;
               count_new = count_x + CMPW'(1);
            end
         end
         OP_POP: begin
            if (count_x == '0) begin
               status_in = ST_UNDERFLOW;
            end else begin
               count_new  = top_idx;
               data_ok_in = 1'b1;
            end
         end
         OP_PEEK: begin
            if (pos_x == '0 || pos_x > count_x) begin
               status_in = ST_BADPEEK;
            end else begin
               rd_idx     = peek_idx;
               data_ok_in = 1'b1;
            end
         end
         OP_TOP: begin
            if (count_x == '0) begin
               status_in = ST_UNDERFLOW;
            end else begin
               data_ok_in = 1'b1;
            end
         end
         OP_BOTTOM: begin
            if (count_x == '0) begin
               status_in = ST_UNDERFLOW;
            end else begin
               rd_idx     = '0;
               data_ok_in = 1'b1;
            end
         end
         OP_STATUS: begin
         end
         default: begin
         end
      endcase
   end

   assign count_in  = count_new[CW-1:0];
   assign empty_in  = (count_new == '0);
   assign full_in   = (count_new >= cap_eff);
   assign push_wide = {32'd0, push_ff};

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         count_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (cmd.exec) begin
            count_ff <= count_in;
         end
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= opcode_type'(req_opcode);
         push_ff <= req_push_value;
         pos_ff  <= req_peek_position;
      end
   end

   // entry memory and result registers
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         if (wr_en) begin
            mem[count_ff[AW-1:0]] <= push_wide[DATA_WIDTH-1:0];
         end
         rd_data_ff <= mem[rd_idx[AW-1:0]];
         status_ff  <= status_in;
         data_ok_ff <= data_ok_in;
         empty_ff   <= empty_in;
         full_ff    <= full_in;
      end
   end

   assign rd_wide         = 64'(rd_data_ff);
   assign rsp_read_data   = data_ok_ff ? signed'(rd_wide[WORD_W-1:0]) : '0;
   assign rsp_status_code = status_ff;
   assign rsp_is_empty    = empty_ff;
   assign rsp_is_full     = full_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(DEPTH), "entry count above depth")
   `ASSERT_NEXT(a_count_hold, clock, reset, !cmd.exec, $stable(count_ff), "count changed without an item")

endmodule

[rtl/lifo_stack_with_peek.sv]
// An accepted item passes through the execute state, then rsp_valid is raised for one cycle.
// busy is high only in the execute state, where the entry memory read is registered; no
// new item is taken then, but the next one may be accepted while the result is on the ports.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Synchronous reset empties the stack, sets the capacity to 16 and idles the
// controller; memory contents are not cleared.
`timescale 1ns / 1ps

module lifo_stack_with_peek import lsp_pkg::*; #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [OPCODE_W-1:0]      req_opcode,
   input  logic signed [WORD_W-1:0] req_push_value,
   input  logic [POS_W-1:0]         req_peek_position,
   output logic                     rsp_valid,
   output logic signed [WORD_W-1:0] rsp_read_data,
   output logic [STATUS_W-1:0]      rsp_status_code,
   output logic                     rsp_is_empty,
   output logic                     rsp_is_full,
   input  logic                     csr_wr_en,
   input  logic [CAP_W-1:0]         csr_wr_data
);

   ctl_cmd_type cmd;

   lsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   lsp_dpath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_opcode        (req_opcode),
      .req_push_value    (req_push_value),
      .req_peek_position (req_peek_position),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_read_data     (rsp_read_data),
      .rsp_status_code   (rsp_status_code),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_is_full       (rsp_is_full)
   );

endmodule

[tb/lifo_stack_with_peek_test.sv]
// Self-checking testbench for the LIFO stack with peek: queued driver, result monitor.
`timescale 1ns / 1ps

module lifo_stack_with_peek_test;
   import lsp_pkg::*;

   localparam int STACK_DEPTH    = 16;
   localparam int RESULT_LATENCY = 2;
   localparam int MAX_REPORTS    = 10;
   localparam int PHASE_ITEMS    = 223;

   // opcodes the block does not define; they behave like a status request
   localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

   typedef struct {
      logic [OPCODE_W-1:0]      opcode;
      logic signed [WORD_W-1:0] push_value;
      logic [POS_W-1:0]         peek_position;
   } stack_req_type;

   typedef struct {
      logic signed [WORD_W-1:0] read_data;
      status_type               status_code;
      logic                     is_empty;
      logic                     is_full;
   } stack_rsp_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [OPCODE_W-1:0]      req_opcode = '0;
   logic signed [WORD_W-1:0] req_push_value = '0;
   logic [POS_W-1:0]         req_peek_position = '0;
   logic                     rsp_valid;
   logic signed [WORD_W-1:0] rsp_read_data;
   logic [STATUS_W-1:0]      rsp_status_code;
   logic                     rsp_is_empty;
   logic                     rsp_is_full;
   logic                     csr_wr_en = 1'b0;
   logic [CAP_W-1:0]         csr_wr_data = '0;

   stack_req_type req_queue[$];
   stack_rsp_type expected_rsps[$];

   // shadow of the stack contents and capacity register
   logic signed [WORD_W-1:0] model_words [STACK_DEPTH];
   int                       model_count = 0;
   logic [CAP_W-1:0]         model_capacity = CAP_RESET;

   int gap_left = 0;
   bit quiet_tail = 1'b0;
   int error_count = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   lifo_stack_with_peek u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_push_value    (req_push_value),
      .req_peek_position (req_peek_position),
      .rsp_valid         (rsp_valid),
      .rsp_read_data     (rsp_read_data),
      .rsp_status_code   (rsp_status_code),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_is_full       (rsp_is_full),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   function automatic stack_rsp_type predict_stack_op(stack_req_type rq);
      stack_rsp_type rs;
      int            cap;
      cap = (model_capacity == 0) ? 1 :
            (model_capacity > STACK_DEPTH) ? STACK_DEPTH : int'(model_capacity);
      rs.read_data   = '0;
      rs.status_code = ST_OK;
      case (rq.opcode)
         OP_PUSH: begin
            if (model_count >= cap) begin
               rs.status_code = ST_OVERFLOW;
            end else begin
               model_words[model_count] = rq.push_value;
               model_count++;
            end
         end
         OP_POP: begin
            if (model_count == 0) begin
               rs.status_code = ST_UNDERFLOW;
            end else begin
               model_count--;
               rs.read_data = model_words[model_count];
            end
         end
         OP_PEEK: begin
            if (rq.peek_position == 0 || int'(rq.peek_position) > model_count) begin
               rs.status_code = ST_BADPEEK;
            end else begin
               rs.read_data = model_words[model_count - int'(rq.peek_position)];
            end
         end
         OP_TOP: begin
            if (model_count == 0) rs.status_code = ST_UNDERFLOW;
            else rs.read_data = model_words[model_count - 1];
         end
         OP_BOTTOM: begin
            if (model_count == 0) rs.status_code = ST_UNDERFLOW;
            else rs.read_data = model_words[0];
         end
         default: ;
      endcase
      rs.is_empty = (model_count == 0);
      rs.is_full  = (model_count >= cap);
      return rs;
   endfunction

   // driver: holds each item until start && !busy, then predicts its result
   always @(posedge clock) begin
      if (reset) begin
         start          <= 1'b0;
         model_count    = 0;
         model_capacity = CAP_RESET;
         gap_left       = 0;
      end else begin
         if (csr_wr_en) model_capacity = csr_wr_data;
         if (start && !busy) begin
            expected_rsps.push_back(predict_stack_op(req_queue.pop_front()));
            if (!quiet_tail && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 3);
         end
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (req_queue.size() > 0) begin
               start             <= 1'b1;
               req_opcode        <= req_queue[0].opcode;
               req_push_value    <= req_queue[0].push_value;
               req_peek_position <= req_queue[0].peek_position;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: every strobed result is matched against the oldest expectation
   always @(posedge clock) begin : result_check
      stack_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("unexpected result: data %0d status %0d empty %0b full %0b",
                        rsp_read_data, rsp_status_code, rsp_is_empty, rsp_is_full);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_read_data !== want.read_data || rsp_status_code !== want.status_code ||
                rsp_is_empty !== want.is_empty || rsp_is_full !== want.is_full) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("mismatch: expected data %0d status %0d empty %0b full %0b, %s",
                           want.read_data, want.status_code, want.is_empty, want.is_full,
                           $sformatf("got data %0d status %0d empty %0b full %0b",
                                     rsp_read_data, rsp_status_code, rsp_is_empty,
                                     rsp_is_full));
            end
         end
      end
   end

   task automatic queue_req(logic [OPCODE_W-1:0] op, logic signed [WORD_W-1:0] value,
                            logic [POS_W-1:0] pos);
      stack_req_type rq;
      rq.opcode        = op;
      rq.push_value    = value;
      rq.peek_position = pos;
      req_queue.push_back(rq);
   endtask

   task automatic queue_random_req(int push_pct);
      logic [OPCODE_W-1:0]      op;
      logic signed [WORD_W-1:0] value;
      logic [POS_W-1:0]         pos;
      int                       pick;
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 99) < push_pct) op = OP_PUSH;
      else if (pick < 4) op = OP_POP;
      else if (pick < 6) op = OP_PEEK;
      else if (pick == 6) op = OP_TOP;
      else if (pick == 7) op = OP_BOTTOM;
      else if (pick == 8) op = OP_STATUS;
      else op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
      case ($urandom_range(0, 19))
         0: value = 32'sh7FFF_FFFF;
         1: value = 32'sh8000_0000;
         2: value = '0;
         3: value = '1;
         default: value = $urandom;
      endcase
      // mostly positions near the top, the rest anywhere in the field
      if ($urandom_range(0, 4) == 0) pos = POS_W'($urandom_range(0, 31));
      else pos = POS_W'($urandom_range(1, $urandom_range(1, STACK_DEPTH)));
      queue_req(op, value, pos);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic wait_drained();
      while (req_queue.size() != 0 || start || expected_rsps.size() != 0) @(posedge clock);
      repeat (RESULT_LATENCY + 2) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [CAP_W-1:0] phase_caps [8];
      int               push_pct;
      int               run_left;
      phase_caps = '{5'd31, 5'd2, 5'd0, 5'd16, 5'd1, 5'd9, 5'd17, 5'd4};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      write_capacity(5'd16);

      // directed: everything on an empty stack, then extreme words and peeks
      queue_req(OP_POP, '0, '0);
      queue_req(OP_TOP, '0, '0);
      queue_req(OP_BOTTOM, '0, '0);
      queue_req(OP_PEEK, '0, 5'd0);
      queue_req(OP_PEEK, '0, 5'd1);
      queue_req(OP_STATUS, '0, '0);
      queue_req(OP_SPARE_LO, '1, '1);
      queue_req(OP_SPARE_HI, '0, '0);
      queue_req(OP_PUSH, 32'sh7FFF_FFFF, '0);
      queue_req(OP_PUSH, 32'sh8000_0000, '1);
      queue_req(OP_PUSH, '0, '0);
      queue_req(OP_PUSH, '1, '0);
      queue_req(OP_PEEK, '0, 5'd0);
      queue_req(OP_PEEK, '0, 5'd1);
      queue_req(OP_PEEK, '0, 5'd4);
      queue_req(OP_PEEK, '0, 5'd5);
      queue_req(OP_PEEK, '1, 5'd31);
      queue_req(OP_TOP, '0, '0);
      queue_req(OP_BOTTOM, '0, '0);
      queue_req(OP_STATUS, '0, '0);
      queue_req(OP_POP, '0, '0);
      wait_drained();

      foreach (phase_caps[p]) begin
         if (p == 7) quiet_tail = 1'b1;
         // capacity changes land on whatever the previous phase left, often a deep stack
         write_capacity(phase_caps[p]);
         push_pct = 65;
         run_left = 0;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (run_left == 0) begin
               push_pct = (push_pct == 65) ? 25 : 65;
               run_left = $urandom_range(20, 60);
            end
            run_left--;
            queue_random_req(push_pct);
         end
         // leave the stack deep so the next capacity may sit below the count
         for (int i = 0; i < 12; i++)
            queue_req(OP_PUSH, $urandom, POS_W'($urandom_range(0, 31)));
         wait_drained();
      end

      repeat (RESULT_LATENCY + 4) @(posedge clock);
      if (expected_rsps.size() != 0) error_count++;
      if (error_count == 0) begin
         $display("lifo_stack_with_peek_test: clean");
      end else begin
         $display("lifo_stack_with_peek_test: errors");
      end
      $finish;
   end

   initial begin : watchdog
      #400000;
      $display("lifo_stack_with_peek_test: errors");
      $finish;
   end

endmodule

[lifo_stack_with_peek.f]
+incdir+rtl
rtl/lsp_pkg.sv
rtl/lsp_ctrl.sv
rtl/lsp_dpath.sv
rtl/lifo_stack_with_peek.sv
tb/lifo_stack_with_peek_test.sv
